// File: src/dlpm_pkg.sv
package dlpm_pkg;

  localparam int unsigned SeenDepth   = 256;
  localparam int unsigned NumPrefixes = 4;
  localparam int unsigned SeenAw      = (SeenDepth > 1) ? $clog2(SeenDepth) : 1;
  localparam int unsigned FillW       = $clog2(SeenDepth + 1);

  localparam int unsigned EntryW = 38;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CountW = 9;

  localparam logic [7:0]         MsgAck   = 8'd5;
  localparam logic [CfgIdxW-1:0] RegInUse = 3'd4;

  typedef struct packed {
    logic       count_en;
    logic       report_en;
    logic [1:0] report_idx;
  } stats_ctrl_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              alert;
    logic [2:0]        used;
  } stats_status_t;

  function automatic logic [5:0] len_of(logic [EntryW-1:0] entry);
    logic [5:0] len;
    len = entry[5:0];
    return (len > 6'd32) ? 6'd32 : len;
  endfunction

  function automatic logic counts_in(logic [EntryW-1:0] entry, logic [31:0] addr);
    logic [5:0]  len;
    logic [31:0] base;
    logic [31:0] mask;
    logic [31:0] net;
    logic [31:0] bc;
    len  = len_of(entry);
    base = entry[37:6];
    mask = (len == 6'd0) ? 32'h0 : (32'hFFFF_FFFF << (6'd32 - len));
    net  = base & mask;
    bc   = base | ~mask;
    return ((addr & mask) == net) && (addr != net) && (addr != bc);
  endfunction

  // Twice the count against the usable host count, floor of one.
  function automatic logic over_half(logic [CountW-1:0] cnt, logic [EntryW-1:0] entry);
    logic [5:0]  len;
    logic [10:0] usable;
    len    = len_of(entry);
    usable = 11'd0;
    if (len >= 6'd31) begin
      return cnt != '0;
    end else if (len < 6'd22) begin
      return 1'b0;
    end
    usable = (11'd1 << (6'd32 - len)) - 11'd2;
    return {1'b0, cnt, 1'b0} > usable;
  endfunction

endpackage

// File: src/dlpm_if.sv
interface dlpm_in_if;
  import dlpm_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  message_type;
  logic [31:0] assigned_address;

  modport source(output valid, output message_type, output assigned_address, input ready);
  modport sink(input valid, input message_type, input assigned_address, output ready);
endinterface

interface dlpm_out_if;
  import dlpm_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        prefix_index;
  logic [CountW-1:0] allocated_count;
  logic              alert_first;
  logic              table_full;
  logic              last_result;

  modport source(output valid, output prefix_index, output allocated_count,
                 output alert_first, output table_full, output last_result, input ready);
  modport sink(input valid, input prefix_index, input allocated_count,
               input alert_first, input table_full, input last_result, output ready);
endinterface

// File: src/dlpm_ram.sv
module dlpm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [Aw-1:0]          waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic                   re_i,
  input  logic [Aw-1:0]          raddr_i,
  output logic [Width-1:0]       rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// File: src/dlpm_prefix_stats.sv
module dlpm_prefix_stats
  import dlpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [EntryW-1:0]   cfg_data_i,
  input  logic [31:0]         addr_i,
  input  stats_ctrl_t         ctrl_i,
  output stats_status_t       stat_o
);
  logic [EntryW-1:0] entry_q   [NumPrefixes];
  logic [2:0]        in_use_q;
  logic [CountW-1:0] count_q   [NumPrefixes];
  logic              alerted_q [NumPrefixes];

  logic [CountW-1:0] rep_count;
  logic              rep_alert;

  always_comb begin
    rep_count = count_q[ctrl_i.report_idx];
    rep_alert = !alerted_q[ctrl_i.report_idx] &&
                over_half(rep_count, entry_q[ctrl_i.report_idx]);
  end

  assign stat_o.count = rep_count;
  assign stat_o.alert = rep_alert;
  assign stat_o.used  = (in_use_q > 3'(NumPrefixes)) ? 3'(NumPrefixes) : in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      for (int i = 0; i < NumPrefixes; i++) begin
        entry_q[i]   <= '0;
        count_q[i]   <= '0;
        alerted_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegInUse) begin
          in_use_q <= cfg_data_i[2:0];
        end
        for (int i = 0; i < NumPrefixes; i++) begin
          if (cfg_idx_i == CfgIdxW'(i)) begin
            entry_q[i] <= cfg_data_i;
          end
        end
      end
      // saturate each count at its maximum
      if (ctrl_i.count_en) begin
        for (int i = 0; i < NumPrefixes; i++) begin
          if (counts_in(entry_q[i], addr_i) && (count_q[i] != '1)) begin
            count_q[i] <= count_q[i] + CountW'(1);
          end
        end
      end
      if (ctrl_i.report_en && rep_alert) begin
        alerted_q[ctrl_i.report_idx] <= 1'b1;
      end
    end
  end
endmodule

// File: src/dhcp_lease_prefix_monitor_core.sv
// DHCP lease prefix monitor. Each input item is one DHCP message; only an
// acknowledgement with a non-zero address not seen before is counted. The
// seen-address table is a single-port-read memory searched one entry per
// cycle until a match or the fill count is reached. An unseen address is
// then stored and counted, after which one result per monitored prefix is
// loaded per cycle while the output is taken; a full table yields just a
// table-full result instead, and a seen address yields none. A new item is
// accepted only once the previous one is fully resolved and its results are
// loaded. The table needs no clearing after reset; only entries below the fill
// count are read.
module dhcp_lease_prefix_monitor_core
  import dlpm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [EntryW-1:0]  cfg_data_i,
  dlpm_in_if.sink            in_i,
  dlpm_out_if.source         out_o
);
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StEmit   = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [31:0]       addr_q;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [FillW-1:0]  rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [1:0]        e_idx_q, e_idx_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        o_idx_q, o_idx_d;
  logic [CountW-1:0] o_cnt_q, o_cnt_d;
  logic              o_alert_q, o_alert_d;
  logic              o_full_q, o_full_d;
  logic              o_last_q, o_last_d;

  logic              ram_re, ram_we;
  logic [31:0]       ram_rdata;
  stats_ctrl_t       ctrl;
  stats_status_t     stat;
  logic              out_free;
  logic              hit;

  dlpm_ram #(.Width(32), .Depth(SeenDepth)) u_seen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[SeenAw-1:0]),
    .wdata_i (addr_q),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[SeenAw-1:0]),
    .rdata_o (ram_rdata)
  );

  dlpm_prefix_stats u_stats (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .addr_i     (addr_q),
    .ctrl_i     (ctrl),
    .stat_o     (stat)
  );

  assign in_i.ready            = (state_q == StIdle);
  assign out_o.valid           = out_valid_q;
  assign out_o.prefix_index    = o_idx_q;
  assign out_o.allocated_count = o_cnt_q;
  assign out_o.alert_first     = o_alert_q;
  assign out_o.table_full      = o_full_q;
  assign out_o.last_result     = o_last_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign hit      = cmp_vld_q && (ram_rdata == addr_q);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    e_idx_d     = e_idx_q;
    out_valid_d = out_valid_q && !out_o.ready;
    o_idx_d     = o_idx_q;
    o_cnt_d     = o_cnt_q;
    o_alert_d   = o_alert_q;
    o_full_d    = o_full_q;
    o_last_d    = o_last_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ctrl        = '{count_en: 1'b0, report_en: 1'b0, report_idx: e_idx_q};

    unique case (state_q)
      StIdle: begin
        if (in_i.valid && (in_i.message_type == MsgAck) &&
            (in_i.assigned_address != 32'h0)) begin
          rd_idx_d = '0;
          state_d  = StSearch;
        end
      end
      StSearch: begin
        if (hit) begin
          // already seen: drop
          state_d = StIdle;
        end else if (rd_idx_q != fill_q) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + FillW'(1);
          cmp_vld_d = 1'b1;
        end else if (fill_q == FillW'(SeenDepth)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            o_idx_d     = '0;
            o_cnt_d     = '0;
            o_alert_d   = 1'b0;
            o_full_d    = 1'b1;
            o_last_d    = 1'b1;
            state_d     = StIdle;
          end
        end else begin
          ram_we        = 1'b1;
          fill_d        = fill_q + FillW'(1);
          ctrl.count_en = 1'b1;
          e_idx_d       = '0;
          state_d       = (stat.used == 3'd0) ? StIdle : StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          ctrl.report_en = 1'b1;
          out_valid_d    = 1'b1;
          o_idx_d        = e_idx_q;
          o_cnt_d        = stat.count;
          o_alert_d      = stat.alert;
          o_full_d       = 1'b0;
          o_last_d       = ({1'b0, e_idx_q} + 3'd1) == stat.used;
          e_idx_d        = e_idx_q + 2'd1;
          if (o_last_d) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      e_idx_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      e_idx_q     <= e_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      addr_q <= in_i.assigned_address;
    end
    o_idx_q   <= o_idx_d;
    o_cnt_q   <= o_cnt_d;
    o_alert_q <= o_alert_d;
    o_full_q  <= o_full_d;
    o_last_q  <= o_last_d;
  end
endmodule

// File: sim/tb_dhcp_lease_prefix_monitor_core.sv
`timescale 1ns / 100ps

module tb_dhcp_lease_prefix_monitor_core;
  import dlpm_pkg::*;

  typedef struct packed {
    logic [1:0]        idx;
    logic [CountW-1:0] count;
    logic              alert;
    logic              full;
    logic              last;
  } lease_report_t;

  localparam int unsigned         SettleCycles  = 300;
  localparam int unsigned         DrainCap      = 50000;
  localparam int unsigned         HoldOffCycles = 400;
  localparam logic [CountW-1:0]   CountSat      = 9'd511;
  localparam logic [CfgIdxW-1:0]  RegPrefix0    = 3'd0;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [EntryW-1:0]  cfg_data;

  dlpm_in_if  in_if ();
  dlpm_out_if out_if ();

  dhcp_lease_prefix_monitor_core u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // lease tracker state, mirrored from the writes and accepted messages
  logic [31:0]       seen_tbl[$];
  logic [CountW-1:0] lease_cnt    [NumPrefixes];
  logic              half_flagged [NumPrefixes];
  logic [EntryW-1:0] prefix_cfg   [NumPrefixes];
  logic [2:0]        in_use_cfg;
  lease_report_t     report_q[$];

  int errors;
  bit in_calm;
  bit rx_calm;
  int rx_hold;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [5:0] eff_len(logic [EntryW-1:0] e);
    return (e[5:0] > 6'd32) ? 6'd32 : e[5:0];
  endfunction

  function automatic logic [31:0] net_mask(logic [5:0] len);
    logic [63:0] wide;
    wide = 64'hFFFF_FFFF_0000_0000 >> len;
    return wide[31:0];
  endfunction

  function automatic logic [32:0] host_room(logic [5:0] len);
    if (len >= 6'd31) begin
      return 33'd1;
    end
    return (33'd1 << (6'd32 - len)) - 33'd2;
  endfunction

  function automatic bit lease_in_prefix(logic [EntryW-1:0] e, logic [31:0] a);
    logic [31:0] m;
    logic [31:0] net;
    logic [31:0] bc;
    m   = net_mask(eff_len(e));
    net = e[37:6] & m;
    bc  = e[37:6] | ~m;
    return ((a & m) == net) && (a != net) && (a != bc);
  endfunction

  function automatic void predict_lease(logic [7:0] t, logic [31:0] a);
    lease_report_t r;
    int            used;
    if (t != MsgAck || a == 32'h0) begin
      return;
    end
    foreach (seen_tbl[k]) begin
      if (seen_tbl[k] == a) begin
        return;
      end
    end
    r = '0;
    if (seen_tbl.size() >= SeenDepth) begin
      r.full = 1'b1;
      r.last = 1'b1;
      report_q.insert(report_q.size(), r);
      return;
    end
    seen_tbl.insert(seen_tbl.size(), a);
    for (int i = 0; i < NumPrefixes; i++) begin
      if (lease_in_prefix(prefix_cfg[i], a) && lease_cnt[i] != CountSat) begin
        lease_cnt[i] = lease_cnt[i] + 1'b1;
      end
    end
    used = (in_use_cfg > NumPrefixes) ? NumPrefixes : in_use_cfg;
    for (int i = 0; i < used; i++) begin
      r       = '0;
      r.idx   = i[1:0];
      r.count = lease_cnt[i];
      if (!half_flagged[i] && {lease_cnt[i], 1'b0} > host_room(eff_len(prefix_cfg[i]))) begin
        half_flagged[i] = 1'b1;
        r.alert         = 1'b1;
      end
      r.last = (i == used - 1);
      report_q.insert(report_q.size(), r);
    end
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] fresh_address();
    logic [31:0] a;
    bit          clash;
    do begin
      a     = $urandom;
      clash = (a == 32'h0);
      foreach (seen_tbl[k]) begin
        if (seen_tbl[k] == a) clash = 1'b1;
      end
    end while (clash);
    return a;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [EntryW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegInUse) begin
      in_use_cfg = data[2:0];
    end else if (idx < NumPrefixes) begin
      prefix_cfg[idx] = data;
    end
    @(posedge clk);
  endtask

  task automatic set_prefix(input int i, input logic [31:0] base, input logic [5:0] len);
    write_reg(RegPrefix0 + i[CfgIdxW-1:0], {base, len});
  endtask

  task automatic set_in_use(input logic [2:0] n);
    write_reg(RegInUse, {{(EntryW - 3){1'b0}}, n});
  endtask

  task automatic send_msg(input logic [7:0] t, input logic [31:0] a);
    int gap;
    gap = in_calm ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid            <= 1'b1;
    in_if.message_type     <= t;
    in_if.assigned_address <= a;
    do @(posedge clk); while (!in_if.ready);
    predict_lease(t, a);
  endtask

  // drop valid, wait for every pending report, then let the search finish
  task automatic wait_drained();
    int waited;
    in_if.valid <= 1'b0;
    waited = 0;
    while (report_q.size() != 0 && waited < DrainCap) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (report_q.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, report_q.size());
      errors += report_q.size();
      report_q.delete();
    end
  endtask

  always @(posedge clk) begin
    lease_report_t got;
    lease_report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.prefix_index, out_if.allocated_count, out_if.alert_first,
             out_if.table_full, out_if.last_result};
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report idx=%0d count=%0d alert=%b full=%b last=%b",
                 $time, got.idx, got.count, got.alert, got.full, got.last);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (got !== want) begin
          $display("%0t: report mismatch expected idx=%0d count=%0d alert=%b full=%b last=%b",
                   $time, want.idx, want.count, want.alert, want.full, want.last);
          $display("%0t:                 actual   idx=%0d count=%0d alert=%b full=%b last=%b",
                   $time, got.idx, got.count, got.alert, got.full, got.last);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else if (!rx_calm) begin
        stall = idle_len();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          stall--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_prefix_edges();
    set_prefix(0, 32'h0A00_0000, 6'd24);
    set_prefix(1, 32'h0A00_0000, 6'd30);
    set_prefix(2, $urandom, 6'd0);
    set_prefix(3, 32'hC0A8_0100, 6'd31);
    set_in_use(3'd4);
    send_msg(MsgAck, 32'h0A00_0001);
    // second host of the /30 crosses half its usable hosts
    send_msg(MsgAck, 32'h0A00_0002);
    send_msg(MsgAck, 32'h0A00_0001);
    send_msg(8'd3, 32'h0A00_0005);
    send_msg(MsgAck, 32'h0000_0000);
    send_msg(MsgAck, 32'h0A00_0000);
    send_msg(MsgAck, 32'h0A00_0003);
    send_msg(MsgAck, 32'h0A00_00FF);
    send_msg(MsgAck, 32'hFFFF_FFFF);
    send_msg(MsgAck, 32'hC0A8_0100);
    send_msg(MsgAck, 32'hC0A8_0101);
    send_msg(8'hFF, 32'hFFFF_FFFF);
    send_msg(8'h00, 32'h0A00_0007);
    wait_drained();
  endtask

  task automatic test_in_use_and_rewrite();
    set_in_use(3'd0);
    send_msg(MsgAck, 32'h0A00_000A);
    send_msg(MsgAck, 32'h0A00_000B);
    send_msg(MsgAck, 32'h0A00_0063);
    wait_drained();
    set_in_use(3'd7);
    // a /32 with an old nonzero count alerts on its next report
    set_prefix(2, 32'h0A00_0014, 6'd32);
    set_prefix(3, 32'h0A00_0000, 6'd63);
    set_prefix(0, 32'hC0A8_0000, 6'd1);
    send_msg(MsgAck, 32'h0A00_0014);
    send_msg(MsgAck, 32'hC0A8_0505);
    send_msg(MsgAck, 32'h8000_0000);
    send_msg(MsgAck, 32'hFFFF_FFFE);
    wait_drained();
  endtask

  task automatic test_output_stall();
    set_in_use(3'd4);
    in_calm = 1'b1;
    rx_hold = HoldOffCycles;
    repeat (10) send_msg(MsgAck, fresh_address());
    in_calm = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int          r;
    int          i;
    logic [5:0]  len;
    logic [31:0] m;
    logic [31:0] base;
    logic [31:0] a;
    logic [7:0]  t;
    for (int phase = 0; phase < 6; phase++) begin
      for (int p = 0; p < NumPrefixes; p++) begin
        r = $urandom_range(0, 99);
        if (r < 20) len = 6'($urandom_range(0, 63));
        else if (r < 30) len = 6'd0;
        else len = 6'($urandom_range(22, 31));
        set_prefix(p, $urandom, len);
      end
      case (phase)
        0: set_in_use(3'd4);
        1: set_in_use(3'd1);
        2: set_in_use(3'd7);
        3: set_in_use(3'd2);
        4: set_in_use(3'd3);
        default: set_in_use(3'd4);
      endcase
      in_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 15; n++) begin
        r    = $urandom_range(0, 99);
        i    = $urandom_range(0, NumPrefixes - 1);
        m    = net_mask(eff_len(prefix_cfg[i]));
        base = prefix_cfg[i][37:6];
        t    = MsgAck;
        if (r < 55) begin
          a = (base & m) | ($urandom & ~m);
        end else if (r < 65) begin
          a = $urandom_range(0, 1) ? (base & m) : (base | ~m);
        end else if (r < 75) begin
          a = $urandom;
        end else if (r < 85 && seen_tbl.size() > 0) begin
          a = seen_tbl[$urandom_range(0, seen_tbl.size() - 1)];
        end else if (r < 93) begin
          t = 8'($urandom_range(0, 255));
          a = $urandom;
        end else begin
          a = 32'h0;
        end
        send_msg(t, a);
      end
      wait_drained();
    end
    in_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_seen_table_full();
    set_in_use(3'd2);
    while (seen_tbl.size() < SeenDepth) begin
      send_msg(MsgAck, fresh_address());
    end
    repeat (4) send_msg(MsgAck, fresh_address());
    send_msg(MsgAck, seen_tbl[$urandom_range(0, SeenDepth - 1)]);
    send_msg(MsgAck, 32'h0);
    wait_drained();
    // the dropped-address report comes even with no prefix monitored
    set_in_use(3'd0);
    repeat (2) send_msg(MsgAck, fresh_address());
    wait_drained();
  endtask

  initial begin
    errors                 = 0;
    in_calm                = 1'b0;
    rx_calm                = 1'b0;
    rx_hold                = 0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_data               = '0;
    in_if.valid            = 1'b0;
    in_if.message_type     = '0;
    in_if.assigned_address = '0;
    in_use_cfg             = '0;
    for (int i = 0; i < NumPrefixes; i++) begin
      lease_cnt[i]    = '0;
      half_flagged[i] = 1'b0;
      prefix_cfg[i]   = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_prefix_edges();
    test_in_use_and_rewrite();
    test_output_stall();
    test_random_traffic();
    test_seen_table_full();

    wait_drained();
    if (errors == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
